// ----- hw/rtl/matrix_add_sub_multiply_unit_assert.svh -----
// assertion macros used by the checker file
`ifndef MATRIX_ADD_SUB_MULTIPLY_UNIT_ASSERT_SVH
`define MATRIX_ADD_SUB_MULTIPLY_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define MASMU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define MASMU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/masmu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package masmu_pkg;

   // element and index widths, grid size and depth, result count and bus widths
   localparam int ELEM_W      = 32;
   localparam int IDX_W       = 2;
   localparam int GRID        = 4;
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int DEPTH       = GRID * GRID;
   localparam int MAX_RESULTS = 16;
   localparam int RES_W       = 4;
   localparam int MODE_W      = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // default matrix dimensions
   localparam int DEF_ROWS  = 4;
   localparam int DEF_INNER = 4;
   localparam int DEF_COLS  = 4;

   // request kinds carried on tuser
   typedef enum logic [1:0] {
      REQ_LOAD_A = 2'd0,
      REQ_LOAD_B = 2'd1,
      REQ_START  = 2'd2
   } req_kind_type;

   // operation modes
   typedef enum logic [MODE_W-1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2
   } mode_type;

   localparam logic [MODE_W-1:0] MODE_RESET = MODE_MUL;

   // sequencer to arithmetic unit controls
   typedef struct packed {
      logic [MODE_W-1:0] op;
      logic              rd_en;
      logic              prod_en;
      logic              acc_en;
      logic              acc_clr;
   } alu_ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/matrix_add_sub_multiply_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Integer matrix engine. Requests on req_ load one element of A or B or
// start a run; op_mode on the csr_ channel picks add, subtract or multiply
// (reset: multiply). A run walks the result matrix in row-major order
// through one read port on each element memory and one shared
// multiply-accumulate unit: each partial product steps through read,
// combine and accumulate, and each result then waits for hand-over until
// the output is free; add and subtract take one partial product per result,
// multiply INNER. At most 16 results are sent, the last with rsp_tlast set.
// Requests are taken only between runs. Element memories come up unwritten
// and need no clearing; every element a run reads must have been loaded
// first. op_mode must be changed only while idle; the block does not check.

module matrix_add_sub_multiply_unit #(
   parameter int ROWS  = masmu_pkg::DEF_ROWS,
   parameter int INNER = masmu_pkg::DEF_INNER,
   parameter int COLS  = masmu_pkg::DEF_COLS
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: [1:0] row_index, [3:2] col_index, [35:4] elem_value, rest zero
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [masmu_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // request: [1:0] req_type
   input  logic [1:0]                         req_tuser,
   // result: [1:0] out_row, [3:2] out_col, [35:4] out_value, rest zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [masmu_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [masmu_pkg::MODE_W-1:0]       csr_data
);
   import masmu_pkg::*;

   localparam int DIM_RI  = (ROWS > INNER) ? ROWS : INNER;
   localparam int DIM_MAX = (DIM_RI > COLS) ? DIM_RI : COLS;
   localparam int DIM_W   = ($clog2(DIM_MAX) > IDX_W) ? $clog2(DIM_MAX) : IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [DIM_W-1:0]  i_ff;
   logic [DIM_W-1:0]  j_ff;
   logic [DIM_W-1:0]  k_ff;
   logic [RES_W-1:0]  res_ff;
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_row_ff;
   logic [IDX_W-1:0]  rsp_col_ff;
   logic [ELEM_W-1:0] rsp_value_ff;
   logic              rsp_last_ff;

   logic              req_fire;
   logic              is_mul;
   logic [DIM_W-1:0]  col_last;
   logic [DIM_W-1:0]  k_last;
   logic              elem_last;
   logic              out_free;
   logic              emit_go;
   logic [DIM_W-1:0]  a_row;
   logic [DIM_W-1:0]  a_col;
   logic [DIM_W-1:0]  b_row;
   logic [DIM_W-1:0]  b_col;
   logic              a_ok;
   logic              b_ok;
   logic [ADDR_W-1:0] req_addr;
   logic [ADDR_W-1:0] a_rd_addr;
   logic [ADDR_W-1:0] b_rd_addr;
   logic [ELEM_W-1:0] a_data;
   logic [ELEM_W-1:0] b_data;
   logic [ELEM_W-1:0] acc;
   alu_ctrl_type      alu_ctrl;

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_addr  = {req_tdata[IDX_W-1:0], req_tdata[2*IDX_W-1:IDX_W]};

   // loop limits: add and subtract walk ROWS x INNER with one step each
   assign is_mul    = (mode_ff == MODE_MUL);
   assign col_last  = is_mul ? DIM_W'(COLS - 1) : DIM_W'(INNER - 1);
   assign k_last    = is_mul ? DIM_W'(INNER - 1) : '0;
   assign elem_last = ((i_ff == DIM_W'(ROWS - 1)) && (j_ff == col_last)) ||
                      (res_ff == RES_W'(MAX_RESULTS - 1));
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_go   = (state_ff == ST_EMIT) && out_free;

   // operand addresses, out-of-grid cells are masked to zero
   assign a_row = i_ff;
   assign a_col = is_mul ? k_ff : j_ff;
   assign b_row = is_mul ? k_ff : i_ff;
   assign b_col = j_ff;
   assign a_ok  = ({1'b0, a_row} < (DIM_W + 1)'(GRID)) && ({1'b0, a_col} < (DIM_W + 1)'(GRID));
   assign b_ok  = ({1'b0, b_row} < (DIM_W + 1)'(GRID)) && ({1'b0, b_col} < (DIM_W + 1)'(GRID));
   assign a_rd_addr = {a_row[IDX_W-1:0], a_col[IDX_W-1:0]};
   assign b_rd_addr = {b_row[IDX_W-1:0], b_col[IDX_W-1:0]};

   // controls for the arithmetic unit
   always_comb begin
      alu_ctrl.op      = mode_ff;
      alu_ctrl.rd_en   = (state_ff == ST_READ);
      alu_ctrl.prod_en = (state_ff == ST_MUL);
      alu_ctrl.acc_en  = (state_ff == ST_ACC);
      alu_ctrl.acc_clr = (k_ff == '0);
   end

   // element memories, loads only happen while idle so no overlap with reads
   masmu_ram u_a_ram (
      .clock   (clock),
      .wr_en   (req_fire && (req_tuser == REQ_LOAD_A)),
      .wr_addr (req_addr),
      .wr_data (req_tdata[2*IDX_W+ELEM_W-1:2*IDX_W]),
      .rd_addr (a_rd_addr),
      .rd_data (a_data)
   );

   masmu_ram u_b_ram (
      .clock   (clock),
      .wr_en   (req_fire && (req_tuser == REQ_LOAD_B)),
      .wr_addr (req_addr),
      .wr_data (req_tdata[2*IDX_W+ELEM_W-1:2*IDX_W]),
      .rd_addr (b_rd_addr),
      .rd_data (b_data)
   );

   masmu_alu u_alu (
      .clock  (clock),
      .ctrl   (alu_ctrl),
      .a_ok   (a_ok),
      .b_ok   (b_ok),
      .a_data (a_data),
      .b_data (b_data),
      .acc    (acc)
   );

   // sequencer, counters and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RESET;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         res_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
         // taken result clears unless a new one replaces it
         if (rsp_valid_ff && rsp_tready && !emit_go) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               i_ff   <= '0;
               j_ff   <= '0;
               k_ff   <= '0;
               res_ff <= '0;
               if (req_fire && (req_tuser == REQ_START) &&
                   (mode_ff inside {MODE_ADD, MODE_SUB, MODE_MUL})) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (k_ff == k_last) begin
                  state_ff <= ST_EMIT;
               end else begin
                  k_ff     <= k_ff + DIM_W'(1);
                  state_ff <= ST_READ;
               end
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_row_ff   <= i_ff[IDX_W-1:0];
                  rsp_col_ff   <= j_ff[IDX_W-1:0];
                  rsp_value_ff <= acc;
                  rsp_last_ff  <= elem_last;
                  k_ff         <= '0;
                  res_ff       <= res_ff + RES_W'(1);
                  if (elem_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_READ;
                     if (j_ff == col_last) begin
                        j_ff <= '0;
                        i_ff <= i_ff + DIM_W'(1);
                     end else begin
                        j_ff <= j_ff + DIM_W'(1);
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 2*IDX_W - ELEM_W){1'b0}},
                        rsp_value_ff, rsp_col_ff, rsp_row_ff};

endmodule

`default_nettype wire

// ----- hw/rtl/masmu_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module masmu_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [masmu_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [masmu_pkg::ELEM_W-1:0]  wr_data,
   input  logic [masmu_pkg::ADDR_W-1:0]  rd_addr,
   output logic [masmu_pkg::ELEM_W-1:0]  rd_data
);
   import masmu_pkg::*;

   logic [ELEM_W-1:0] mem [DEPTH];
   logic [ELEM_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/masmu_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module masmu_alu (
   input  logic                          clock,
   input  masmu_pkg::alu_ctrl_type       ctrl,
   input  logic                          a_ok,
   input  logic                          b_ok,
   input  logic [masmu_pkg::ELEM_W-1:0]  a_data,
   input  logic [masmu_pkg::ELEM_W-1:0]  b_data,
   output logic [masmu_pkg::ELEM_W-1:0]  acc
);
   import masmu_pkg::*;

   logic                a_ok_ff;
   logic                b_ok_ff;
   logic [ELEM_W-1:0]   a_val;
   logic [ELEM_W-1:0]   b_val;
   logic [ELEM_W-1:0]   mul_low;
   logic [ELEM_W-1:0]   prod_in;
   logic [ELEM_W-1:0]   prod_ff;
   logic [ELEM_W-1:0]   acc_in;
   logic [ELEM_W-1:0]   acc_ff;

   // cells outside the grid read as zero, flag follows the memory latency
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         a_ok_ff <= a_ok;
         b_ok_ff <= b_ok;
      end
   end

   assign a_val   = a_ok_ff ? a_data : '0;
   assign b_val   = b_ok_ff ? b_data : '0;
   // only the low word of the product is kept, same for signed and unsigned
   assign mul_low = a_val * b_val;

   // operand combine, wraps modulo 2^32
   always_comb begin
      case (ctrl.op)
         MODE_ADD: prod_in = a_val + b_val;
         MODE_SUB: prod_in = a_val - b_val;
         default:  prod_in = mul_low;
      endcase
   end

   assign acc_in = (ctrl.acc_clr ? '0 : acc_ff) + prod_ff;

   // product stage then accumulator
   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/masmu_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_add_sub_multiply_unit_assert.svh"

module masmu_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [masmu_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic [1:0]                         req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [masmu_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                               rsp_tlast,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic [masmu_pkg::MODE_W-1:0]       csr_data
);
   import masmu_pkg::*;

   logic load_fire;
   logic pad_zero;

   assign load_fire = req_tvalid && req_tready && (req_tuser != REQ_START);
   assign pad_zero  = (rsp_tdata[RSP_TDATA_W-1:2*IDX_W+ELEM_W] == '0);

   // a stalled result holds still
   `MASMU_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   // a load or ignored request never starts a run
   `MASMU_ASSERT_NEXT(a_load_stays_idle, load_fire, req_tready,
      "request path closed after a load")

   // a result that is not the last means the run is still going
   `MASMU_ASSERT_NOW(a_mid_run_busy, rsp_tvalid && !rsp_tlast, !req_tready,
      "request taken in the middle of a run")

   // result padding bits stay zero
   `MASMU_ASSERT_NOW(a_rsp_pad, rsp_tvalid, pad_zero, "result padding not zero")

endmodule

bind matrix_add_sub_multiply_unit masmu_checker u_masmu_checker (.*);

`default_nettype wire
